// ===== hw/rtl/rvde_pkg.sv =====
// Shared types and encodings for the RV32I decode and execute unit.
package rvde_pkg;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;

  localparam logic [31:0] JALR_MASK = ~32'd1;

  localparam logic [2:0] F3_JALR = 3'd0;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  typedef enum logic [3:0] {
    MEM_NONE = 4'd0,
    MEM_LB   = 4'd1,
    MEM_LH   = 4'd2,
    MEM_LW   = 4'd3,
    MEM_LBU  = 4'd4,
    MEM_LHU  = 4'd5,
    MEM_SB   = 4'd6,
    MEM_SH   = 4'd7,
    MEM_SW   = 4'd8
  } mem_kind_t;

  typedef enum logic [3:0] {
    CL_LUI,
    CL_AUIPC,
    CL_JAL,
    CL_JALR,
    CL_BRANCH,
    CL_LOAD,
    CL_STORE,
    CL_OPIMM,
    CL_OP,
    CL_NONE
  } op_class_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [31:0] predicted_pc;
    logic [31:0] instr_pc;
    logic [31:0] rs2_value;
    logic [31:0] rs1_value;
    logic [31:0] instruction;
  } in_t;

  // Result item, last field in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [2:0]  pad;
    logic        illegal;
    logic        mispredict;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic [31:0] store_data;
    logic [31:0] mem_address;
    mem_kind_t   mem_kind;
    logic [31:0] result_value;
    logic        dest_write;
    logic [4:0]  dest_index;
  } res_t;

  // Decoded instruction handed from decode to execute.
  typedef struct packed {
    op_class_t   op;
    logic [2:0]  funct3;
    logic        alt;
    logic [4:0]  rd;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic        illegal;
  } dec_t;

endpackage

// ===== hw/rtl/rvde_decode.sv =====
// Instruction decode: operation class, immediates and illegal encoding check.
module rvde_decode (
  input  logic [31:0]   instruction,
  output rvde_pkg::dec_t dec
);

  logic [6:0] opc;
  logic [2:0] f3;

  assign opc = instruction[6:0];
  assign f3  = instruction[14:12];

  always_comb begin
    dec.funct3 = f3;
    dec.rd     = instruction[11:7];
    dec.imm_i  = {{20{instruction[31]}}, instruction[31:20]};
    dec.imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    dec.imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
                  instruction[30:25], instruction[11:8], 1'b0};
    dec.imm_u  = {instruction[31:12], 12'd0};
    dec.imm_j  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                  instruction[20], instruction[30:21], 1'b0};
    dec.alt     = 1'b0;
    dec.illegal = 1'b0;
    dec.op      = rvde_pkg::CL_NONE;
    case (opc)
      rvde_pkg::OPC_LUI:   dec.op = rvde_pkg::CL_LUI;
      rvde_pkg::OPC_AUIPC: dec.op = rvde_pkg::CL_AUIPC;
      rvde_pkg::OPC_JAL:   dec.op = rvde_pkg::CL_JAL;
      rvde_pkg::OPC_JALR: begin
        dec.op      = rvde_pkg::CL_JALR;
        dec.illegal = (f3 != rvde_pkg::F3_JALR);
      end
      rvde_pkg::OPC_BRANCH: begin
        dec.op      = rvde_pkg::CL_BRANCH;
        dec.illegal = !((f3 == rvde_pkg::F3_BEQ) || (f3 == rvde_pkg::F3_BNE) ||
                        (f3 == rvde_pkg::F3_BLT) || (f3 == rvde_pkg::F3_BGE) ||
                        (f3 == rvde_pkg::F3_BLTU) || (f3 == rvde_pkg::F3_BGEU));
      end
      rvde_pkg::OPC_LOAD: begin
        dec.op      = rvde_pkg::CL_LOAD;
        dec.illegal = !((f3 == rvde_pkg::F3_B) || (f3 == rvde_pkg::F3_H) ||
                        (f3 == rvde_pkg::F3_W) || (f3 == rvde_pkg::F3_BU) ||
                        (f3 == rvde_pkg::F3_HU));
      end
      rvde_pkg::OPC_STORE: begin
        dec.op      = rvde_pkg::CL_STORE;
        dec.illegal = (f3 > rvde_pkg::F3_W);
      end
      rvde_pkg::OPC_OPIMM: begin
        dec.op  = rvde_pkg::CL_OPIMM;
        dec.alt = (f3 == rvde_pkg::F3_SR) && instruction[30];
      end
      rvde_pkg::OPC_OP: begin
        dec.op  = rvde_pkg::CL_OP;
        dec.alt = ((f3 == rvde_pkg::F3_ADD) || (f3 == rvde_pkg::F3_SR)) && instruction[30];
      end
      default: dec.illegal = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/rvde_execute.sv =====
// Execute: ALU, branch compare, jump targets and memory request for one item.
module rvde_execute (
  input  rvde_pkg::in_t  item,
  input  rvde_pkg::dec_t dec,
  output rvde_pkg::res_t res
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] opnd;
  logic [4:0]  sh;
  logic [31:0] alu_out;
  logic [31:0] pc4;
  logic [31:0] br_target;
  logic        taken;
  logic        wr;
  logic [31:0] npc;

  assign a    = item.rs1_value;
  assign b    = item.rs2_value;
  assign opnd = (dec.op == rvde_pkg::CL_OP) ? b : dec.imm_i;
  assign sh   = opnd[4:0];
  assign pc4  = item.instr_pc + 32'd4;
  assign br_target = item.instr_pc + dec.imm_b;

  always_comb begin
    case (dec.funct3)
      rvde_pkg::F3_ADD:  alu_out = dec.alt ? a - opnd : a + opnd;
      rvde_pkg::F3_SLL:  alu_out = a << sh;
      rvde_pkg::F3_SLT:  alu_out = {31'd0, $signed(a) < $signed(opnd)};
      rvde_pkg::F3_SLTU: alu_out = {31'd0, a < opnd};
      rvde_pkg::F3_XOR:  alu_out = a ^ opnd;
      rvde_pkg::F3_SR:   alu_out = dec.alt ? 32'($signed(a) >>> sh) : a >> sh;
      rvde_pkg::F3_OR:   alu_out = a | opnd;
      rvde_pkg::F3_AND:  alu_out = a & opnd;
      default:           alu_out = a & opnd;
    endcase
  end

  always_comb begin
    case (dec.funct3)
      rvde_pkg::F3_BEQ:  taken = (a == b);
      rvde_pkg::F3_BNE:  taken = (a != b);
      rvde_pkg::F3_BLT:  taken = $signed(a) < $signed(b);
      rvde_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
      rvde_pkg::F3_BLTU: taken = (a < b);
      rvde_pkg::F3_BGEU: taken = (a >= b);
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    wr  = 1'b0;
    npc = pc4;
    res = '0;
    res.dest_index = dec.rd;
    res.mem_kind   = rvde_pkg::MEM_NONE;
    case (dec.op)
      rvde_pkg::CL_LUI: begin
        wr = 1'b1;
        res.result_value = dec.imm_u;
      end
      rvde_pkg::CL_AUIPC: begin
        wr = 1'b1;
        res.result_value = item.instr_pc + dec.imm_u;
      end
      rvde_pkg::CL_JAL: begin
        wr = 1'b1;
        res.result_value = pc4;
        npc = item.instr_pc + dec.imm_j;
      end
      rvde_pkg::CL_JALR: begin
        wr = 1'b1;
        res.result_value = pc4;
        npc = (a + dec.imm_i) & rvde_pkg::JALR_MASK;
      end
      rvde_pkg::CL_BRANCH: begin
        res.branch_taken = taken;
        npc = taken ? br_target : pc4;
        res.mispredict = (npc != item.predicted_pc);
      end
      rvde_pkg::CL_LOAD: begin
        res.mem_address = a + dec.imm_i;
        case (dec.funct3)
          rvde_pkg::F3_B:  res.mem_kind = rvde_pkg::MEM_LB;
          rvde_pkg::F3_H:  res.mem_kind = rvde_pkg::MEM_LH;
          rvde_pkg::F3_W:  res.mem_kind = rvde_pkg::MEM_LW;
          rvde_pkg::F3_BU: res.mem_kind = rvde_pkg::MEM_LBU;
          rvde_pkg::F3_HU: res.mem_kind = rvde_pkg::MEM_LHU;
          default:         res.mem_kind = rvde_pkg::MEM_NONE;
        endcase
      end
      rvde_pkg::CL_STORE: begin
        res.mem_address = a + dec.imm_s;
        res.store_data  = b;
        case (dec.funct3)
          rvde_pkg::F3_B: res.mem_kind = rvde_pkg::MEM_SB;
          rvde_pkg::F3_H: res.mem_kind = rvde_pkg::MEM_SH;
          rvde_pkg::F3_W: res.mem_kind = rvde_pkg::MEM_SW;
          default:        res.mem_kind = rvde_pkg::MEM_NONE;
        endcase
      end
      rvde_pkg::CL_OPIMM, rvde_pkg::CL_OP: begin
        wr = 1'b1;
        res.result_value = alu_out;
      end
      default: wr = 1'b0;
    endcase
    // Illegal encodings: drop every effect, fall through to pc + 4.
    if (dec.illegal) begin
      res = '0;
      res.dest_index = dec.rd;
      res.mem_kind   = rvde_pkg::MEM_NONE;
      res.illegal    = 1'b1;
      wr  = 1'b0;
      npc = pc4;
    end
    res.next_pc    = npc;
    res.dest_write = wr && (dec.rd != 5'd0);
  end

endmodule

// ===== hw/rtl/rv32i_decode_execute.sv =====
// Top level of the RV32I decode and execute unit: input register, logic, result register.
// One instruction item per cycle sustained while the master side is ready. An accepted
// item is captured in the input register, decoded and executed combinationally from it,
// and moves into the result register when that register is free or being read, from
// where its result is offered on the master side. The result register and the input
// register form a two-entry pipeline: the slave side keeps taking items while a
// result waits, and stalls only when both registers hold items and the master side is
// not ready. There is no kept state between items.
module rv32i_decode_execute (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instruction[31:0], rs1_value[63:32], rs2_value[95:64], instr_pc[127:96],
  // predicted_pc[159:128]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dest_index[4:0], dest_write[5], result_value[37:6], mem_kind[41:38],
  // mem_address[73:42], store_data[105:74], next_pc[137:106], branch_taken[138],
  // mispredict[139], illegal[140], zero[143:141]
  output logic [143:0] m_tdata
);

  rvde_pkg::in_t  s1_item;
  logic           s1_valid;
  rvde_pkg::dec_t dec;
  rvde_pkg::res_t res;
  rvde_pkg::res_t out_item;
  logic           out_load;

  assign out_load = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_load;
  assign m_tdata  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) s1_valid <= s_tvalid;
      if (out_load) m_tvalid <= s1_valid;
    end
    if (s_tvalid && s_tready) s1_item <= s_tdata;
    if (out_load && s1_valid) out_item <= res;
  end

  rvde_decode u_decode (
    .instruction (s1_item.instruction),
    .dec         (dec)
  );

  rvde_execute u_execute (
    .item (s1_item),
    .dec  (dec),
    .res  (res)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled while the pipeline has room");

  a_advance_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> m_tvalid)
    else $error("item in input register lost on advance");

  a_illegal_no_effect: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.illegal) |->
      (!out_item.dest_write && out_item.mem_kind == rvde_pkg::MEM_NONE &&
       !out_item.branch_taken && !out_item.mispredict))
    else $error("illegal item carries an effect");

  a_write_no_mem: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.dest_write) |->
      (out_item.mem_kind == rvde_pkg::MEM_NONE && out_item.dest_index != 5'd0))
    else $error("register write mixed with memory access or x0");

  a_taken_not_mem: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.branch_taken) |->
      (!out_item.dest_write && out_item.mem_kind == rvde_pkg::MEM_NONE))
    else $error("taken branch with write or memory access");

endmodule

// ===== tb/testbench.sv =====
// Testbench for rv32i_decode_execute: directed and random instruction items.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 48;
  localparam int TAIL_CYCLES    = 4;

  // Encodings the package does not name
  localparam logic [2:0] F3_BR_BAD = 3'd2;
  localparam logic [2:0] F3_LD_BAD = 3'd6;
  localparam logic [2:0] F3_ST_BAD = 3'd3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;

  rvde_pkg::res_t pending_results[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  bit   tx_idle_en = 1'b0;
  bit   rx_idle_en = 1'b0;
  bit   hold_request = 1'b0;

  rv32i_decode_execute dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    // instruction, rs1_value, rs2_value, instr_pc, predicted_pc
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    // dest_index, dest_write, result_value, mem_kind, mem_address, store_data,
    // next_pc, branch_taken, mispredict, illegal, zero pad
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] alu_result(logic [2:0] f3, logic alt, logic [31:0] a,
                                             logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      rvde_pkg::F3_ADD:  return alt ? a - b : a + b;
      rvde_pkg::F3_SLL:  return a << sh;
      rvde_pkg::F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      rvde_pkg::F3_SLTU: return {31'd0, a < b};
      rvde_pkg::F3_XOR:  return a ^ b;
      rvde_pkg::F3_SR:   return alt ? $unsigned($signed(a) >>> sh) : a >> sh;
      rvde_pkg::F3_OR:   return a | b;
      default:           return a & b;
    endcase
  endfunction

  function automatic rvde_pkg::res_t execute_instr(rvde_pkg::in_t it);
    logic [31:0] ins, a, b, pc, pc4;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [2:0]  f3;
    logic        wr, taken, bad;
    rvde_pkg::res_t r;
    ins   = it.instruction;
    a     = it.rs1_value;
    b     = it.rs2_value;
    pc    = it.instr_pc;
    pc4   = pc + 32'd4;
    f3    = ins[14:12];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_u = {ins[31:12], 12'd0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    r = '0;
    wr = 1'b0;
    taken = 1'b0;
    bad = 1'b0;
    r.next_pc = pc4;
    case (ins[6:0])
      rvde_pkg::OPC_LUI: begin
        wr = 1'b1;
        r.result_value = imm_u;
      end
      rvde_pkg::OPC_AUIPC: begin
        wr = 1'b1;
        r.result_value = pc + imm_u;
      end
      rvde_pkg::OPC_JAL: begin
        wr = 1'b1;
        r.result_value = pc4;
        r.next_pc = pc + imm_j;
      end
      rvde_pkg::OPC_JALR: begin
        if (f3 != rvde_pkg::F3_JALR) begin
          bad = 1'b1;
        end else begin
          wr = 1'b1;
          r.result_value = pc4;
          r.next_pc = (a + imm_i) & rvde_pkg::JALR_MASK;
        end
      end
      rvde_pkg::OPC_BRANCH: begin
        case (f3)
          rvde_pkg::F3_BEQ:  taken = (a == b);
          rvde_pkg::F3_BNE:  taken = (a != b);
          rvde_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
          rvde_pkg::F3_BGE:  taken = !($signed(a) < $signed(b));
          rvde_pkg::F3_BLTU: taken = (a < b);
          rvde_pkg::F3_BGEU: taken = (a >= b);
          default:           bad = 1'b1;
        endcase
        if (taken) r.next_pc = pc + imm_b;
        r.branch_taken = taken;
        r.mispredict = (r.next_pc != it.predicted_pc);
      end
      rvde_pkg::OPC_LOAD: begin
        case (f3)
          rvde_pkg::F3_B:  r.mem_kind = rvde_pkg::MEM_LB;
          rvde_pkg::F3_H:  r.mem_kind = rvde_pkg::MEM_LH;
          rvde_pkg::F3_W:  r.mem_kind = rvde_pkg::MEM_LW;
          rvde_pkg::F3_BU: r.mem_kind = rvde_pkg::MEM_LBU;
          rvde_pkg::F3_HU: r.mem_kind = rvde_pkg::MEM_LHU;
          default:         bad = 1'b1;
        endcase
        r.mem_address = a + imm_i;
      end
      rvde_pkg::OPC_STORE: begin
        case (f3)
          rvde_pkg::F3_B: r.mem_kind = rvde_pkg::MEM_SB;
          rvde_pkg::F3_H: r.mem_kind = rvde_pkg::MEM_SH;
          rvde_pkg::F3_W: r.mem_kind = rvde_pkg::MEM_SW;
          default:        bad = 1'b1;
        endcase
        r.mem_address = a + imm_s;
        r.store_data = b;
      end
      rvde_pkg::OPC_OPIMM: begin
        wr = 1'b1;
        r.result_value = alu_result(f3, (f3 == rvde_pkg::F3_SR) && ins[30], a, imm_i);
      end
      rvde_pkg::OPC_OP: begin
        wr = 1'b1;
        r.result_value = alu_result(f3, ((f3 == rvde_pkg::F3_ADD) ||
                                         (f3 == rvde_pkg::F3_SR)) && ins[30], a, b);
      end
      default: bad = 1'b1;
    endcase
    // Illegal encodings clear everything but the pc advance and the destination index
    if (bad) begin
      r = '0;
      wr = 1'b0;
      r.next_pc = pc4;
      r.illegal = 1'b1;
    end
    r.dest_index = ins[11:7];
    r.dest_write = wr && (ins[11:7] != 5'd0);
    return r;
  endfunction

  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] f5, logic [2:0] f3,
                                      logic [4:0] rd, logic [6:0] opc);
    return {f7, f5, 5'd9, f3, rd, opc};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic rvde_pkg::in_t random_item();
    rvde_pkg::in_t  it;
    rvde_pkg::res_t probe;
    logic [31:0]    w;
    w = $urandom;
    // Most items carry a known opcode; the rest are raw noise
    if ($urandom_range(0, 99) >= 15) begin
      case ($urandom_range(0, 8))
        0:       w[6:0] = rvde_pkg::OPC_LUI;
        1:       w[6:0] = rvde_pkg::OPC_AUIPC;
        2:       w[6:0] = rvde_pkg::OPC_JAL;
        3:       w[6:0] = rvde_pkg::OPC_JALR;
        4:       w[6:0] = rvde_pkg::OPC_BRANCH;
        5:       w[6:0] = rvde_pkg::OPC_LOAD;
        6:       w[6:0] = rvde_pkg::OPC_STORE;
        7:       w[6:0] = rvde_pkg::OPC_OPIMM;
        default: w[6:0] = rvde_pkg::OPC_OP;
      endcase
      if (w[6:0] == rvde_pkg::OPC_JALR && $urandom_range(0, 3) != 0)
        w[14:12] = rvde_pkg::F3_JALR;
    end
    it.instruction  = w;
    it.rs1_value    = rand_word();
    it.rs2_value    = rand_word();
    it.instr_pc     = rand_word();
    it.predicted_pc = '0;
    if (w[6:0] == rvde_pkg::OPC_BRANCH && $urandom_range(0, 3) == 0)
      it.rs2_value = it.rs1_value;
    probe = execute_instr(it);
    case ($urandom_range(0, 2))
      0:       it.predicted_pc = it.instr_pc + 32'd4;
      1:       it.predicted_pc = probe.next_pc;
      default: it.predicted_pc = rand_word();
    endcase
    return it;
  endfunction

  // Entered and left at a falling edge
  task automatic send_item(rvde_pkg::in_t it);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = it;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(execute_instr(it));
    @(negedge clk);
  endtask

  task automatic send_instr(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
                            logic [31:0] pc, logic [31:0] ppc);
    rvde_pkg::in_t it;
    it.instruction  = ins;
    it.rs1_value    = a;
    it.rs2_value    = b;
    it.instr_pc     = pc;
    it.predicted_pc = ppc;
    send_item(it);
  endtask

  task automatic test_alu_ops();
    send_instr(enc(7'h00, 5'd2, rvde_pkg::F3_ADD, 5'd1, rvde_pkg::OPC_OP), 32'hffff_ffff,
               32'h1, 32'h100, 32'h0);
    // Bit 30 picks SUB; the other funct7 bits do not matter
    send_instr(enc(7'h7f, 5'd2, rvde_pkg::F3_ADD, 5'd5, rvde_pkg::OPC_OP), 32'h0, 32'h1,
               32'h104, 32'h0);
    send_instr(enc(7'h00, 5'd2, rvde_pkg::F3_SLL, 5'd6, rvde_pkg::OPC_OP), 32'h8000_0001,
               32'hffff_ffe1, 32'h108, 32'h0);
    send_instr(enc(7'h20, 5'd2, rvde_pkg::F3_SR, 5'd7, rvde_pkg::OPC_OP), 32'h8000_0000,
               32'h0000_003f, 32'h10c, 32'h0);
    send_instr(enc(7'h00, 5'd2, rvde_pkg::F3_SLT, 5'd8, rvde_pkg::OPC_OP), 32'h8000_0000,
               32'h7fff_ffff, 32'h110, 32'h0);
    send_instr(enc(7'h7f, 5'd2, rvde_pkg::F3_XOR, 5'd0, rvde_pkg::OPC_OP), 32'haaaa_aaaa,
               32'hffff_ffff, 32'h114, 32'h0);
    send_instr(enc(7'h20, 5'd31, rvde_pkg::F3_SR, 5'd9, rvde_pkg::OPC_OPIMM), 32'hffff_0000,
               32'h0, 32'h118, 32'h0);
    send_instr(enc(7'h7f, 5'h1f, rvde_pkg::F3_SLTU, 5'd10, rvde_pkg::OPC_OPIMM),
               32'hffff_fffe, 32'h0, 32'h11c, 32'h0);
  endtask

  task automatic test_upper_and_jumps();
    send_instr(32'hffff_f0b7, 32'h1234_5678, 32'h0, 32'h200, 32'h0);
    send_instr(32'h8000_0097, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
    send_instr(32'h8000_00ef, 32'h0, 32'h0, 32'h0000_0000, 32'h0);
    // Odd target: bit 0 dropped, link wraps past the top of memory
    send_instr(enc(7'h00, 5'd0, rvde_pkg::F3_JALR, 5'd1, rvde_pkg::OPC_JALR), 32'h7, 32'h0,
               32'hffff_fffc, 32'h0);
    send_instr(enc(7'h00, 5'd0, ~rvde_pkg::F3_JALR, 5'd1, rvde_pkg::OPC_JALR), 32'h7, 32'h0,
               32'h300, 32'h0);
  endtask

  task automatic test_branches();
    send_instr(enc(7'h00, 5'd2, rvde_pkg::F3_BEQ, 5'd8, rvde_pkg::OPC_BRANCH), 32'h5, 32'h5,
               32'h400, 32'h408);
    send_instr(enc(7'h00, 5'd2, rvde_pkg::F3_BNE, 5'd8, rvde_pkg::OPC_BRANCH), 32'h5, 32'h5,
               32'h400, 32'h0);
    send_instr(enc(7'h40, 5'd2, rvde_pkg::F3_BLT, 5'd1, rvde_pkg::OPC_BRANCH),
               32'h8000_0000, 32'h0, 32'h400, 32'h404);
    send_instr(enc(7'h3f, 5'd2, rvde_pkg::F3_BGEU, 5'h1e, rvde_pkg::OPC_BRANCH), 32'h0,
               32'hffff_ffff, 32'h400, 32'h404);
    send_instr(enc(7'h00, 5'd2, F3_BR_BAD, 5'd8, rvde_pkg::OPC_BRANCH), 32'h5, 32'h5,
               32'h400, 32'h0);
  endtask

  task automatic test_memory_ops();
    send_instr(enc(7'h7f, 5'h1f, rvde_pkg::F3_B, 5'd3, rvde_pkg::OPC_LOAD), 32'h0, 32'h55,
               32'h500, 32'h0);
    send_instr(enc(7'h3f, 5'h1f, rvde_pkg::F3_HU, 5'd4, rvde_pkg::OPC_LOAD), 32'h8000_0000,
               32'h0, 32'h504, 32'h0);
    send_instr(enc(7'h00, 5'd0, F3_LD_BAD, 5'd4, rvde_pkg::OPC_LOAD), 32'h10, 32'h20,
               32'h508, 32'h0);
    send_instr(enc(7'h40, 5'd2, rvde_pkg::F3_W, 5'd0, rvde_pkg::OPC_STORE), 32'h0,
               32'hdead_beef, 32'h50c, 32'h0);
    send_instr(enc(7'h3f, 5'd2, rvde_pkg::F3_B, 5'h1f, rvde_pkg::OPC_STORE), 32'hffff_ffff,
               32'hffff_ffff, 32'h510, 32'h0);
    send_instr(enc(7'h00, 5'd2, F3_ST_BAD, 5'd4, rvde_pkg::OPC_STORE), 32'h10, 32'h20,
               32'h514, 32'h0);
  endtask

  task automatic test_unknown_opcodes();
    send_instr(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffc, 32'hffff_ffff);
    send_instr(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h600, 32'h604);
  endtask

  task automatic test_random_mix(int count);
    int i;
    for (i = 0; i < count; i++) begin
      // Reshuffle idling every hundred items so some stretches run clean
      if (i % 100 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_item(random_item());
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 30; i++) send_item(random_item());
  endtask

  task automatic test_drain_pause();
    int i;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (i = 0; i < 40; i++) send_item(random_item());
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    for (i = 0; i < 40; i++) send_item(random_item());
  endtask

  task automatic test_streaming(int count);
    int i;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (i = 0; i < count; i++) send_item(random_item());
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver: random bursts of back-pressure plus an occasional long hold
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    rvde_pkg::res_t want;
    rvde_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
        check_field("dest_write", 32'(want.dest_write), 32'(got.dest_write));
        check_field("result_value", want.result_value, got.result_value);
        check_field("mem_kind", 32'(want.mem_kind), 32'(got.mem_kind));
        check_field("mem_address", want.mem_address, got.mem_address);
        check_field("store_data", want.store_data, got.store_data);
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
        check_field("mispredict", 32'(want.mispredict), 32'(got.mispredict));
        check_field("illegal", 32'(want.illegal), 32'(got.illegal));
        check_field("pad", 32'(want.pad), 32'(got.pad));
      end
    end
  end

  // Watchdog: end the run if no item moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_alu_ops();
    test_upper_and_jumps();
    test_branches();
    test_memory_ops();
    test_unknown_opcodes();
    test_random_mix(1200);
    test_output_backpressure();
    test_drain_pause();
    test_streaming(400);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
